### hw/rtl/sset_pkg.sv
// ----------------------------------------------------------------------------
// Sorted set package
// Shared constants, request codes and item types of the sorted set block.
// ----------------------------------------------------------------------------
package sset_pkg;

  localparam int CAPACITY    = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int ADDR_W      = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  localparam logic [VALUE_WIDTH-1:0] KEY_SIGN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  typedef logic [VALUE_WIDTH-1:0] key_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic       found;
    logic       status;
    logic [6:0] count;
  } rsp_t;

  typedef struct packed {
    logic ge;
    logic eq;
  } cmp_res_t;

endpackage

### hw/rtl/sset_mem.sv
// ----------------------------------------------------------------------------
// Sorted set value memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sset_mem
  import sset_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  key_t              wdata,
  input  logic [ADDR_W-1:0] raddr,
  output key_t              rdata
);

  key_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/sset_cmp.sv
// ----------------------------------------------------------------------------
// Sorted set key comparator
// Compares a stored key against the request key in sign-biased order.
// ----------------------------------------------------------------------------
module sset_cmp
  import sset_pkg::*;
(
  input  key_t     entry,
  input  key_t     key,
  output cmp_res_t res
);

  assign res.ge = (entry >= key);
  assign res.eq = (entry == key);

endmodule

### hw/rtl/sorted_set_insert_lookup.sv
// The block keeps up to 64 distinct signed values in ascending order in a
// single-port-read memory and answers one request at a time: clear, insert or
// membership query, each returning one item with found, status and count.
// A clear or an unused request code goes straight to the output state. A
// query or insert scans the held values from the lowest, one entry at a time
// through a read state and a compare state, using the memory's registered
// read port and the one comparator, until it reaches the first entry not
// below the value or the end of the set. An insert of a value not yet held
// into a set that is not full then moves each higher entry up one place and
// writes the new value. A finished result waits in an output register, and
// the next request is taken while it waits.
// ----------------------------------------------------------------------------
// Sorted set with insert and membership query
// Top level: request sequencer, output register and assertions.
// ----------------------------------------------------------------------------
module sorted_set_insert_lookup
  import sset_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_CMP, S_DECIDE, S_SHRD, S_SHWR, S_PUT, S_OUT
  } state_t;

  state_t            state;
  logic [1:0]        req_code;
  key_t              key;
  logic [CNT_W-1:0]  held;
  logic [ADDR_W-1:0] idx;
  logic [CNT_W-1:0]  pos;
  logic [CNT_W-1:0]  shift_idx;
  logic              res_found;
  logic              res_status;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  key_t              mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  key_t              mem_rdata;
  cmp_res_t          cmp;
  logic [CNT_W-1:0]  idx_inc;
  logic [CNT_W-1:0]  shift_dec;

  assign req_ready = (state == S_IDLE);
  assign idx_inc   = CNT_W'(idx) + CNT_W'(1);
  assign shift_dec = shift_idx - CNT_W'(1);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = shift_idx[ADDR_W-1:0];
    mem_wdata = mem_rdata;
    mem_raddr = idx;
    case (state)
      S_SHRD: begin
        mem_raddr = shift_dec[ADDR_W-1:0];
      end
      S_SHWR: begin
        mem_we = 1'b1;
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = pos[ADDR_W-1:0];
        mem_wdata = key;
      end
      default: begin
      end
    endcase
  end

  sset_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sset_cmp u_cmp (
    .entry (mem_rdata),
    .key   (key),
    .res   (cmp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      held      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && state != S_OUT) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            req_code   <= req.req_type;
            key        <= req.value[VALUE_WIDTH-1:0] ^ KEY_SIGN;
            idx        <= '0;
            pos        <= '0;
            res_found  <= 1'b0;
            res_status <= 1'b0;
            if (req.req_type == REQ_INSERT || req.req_type == REQ_QUERY) begin
              state <= (held == '0) ? S_DECIDE : S_RD;
            end else begin
              if (req.req_type == REQ_CLEAR) begin
                held <= '0;
              end
              state <= S_OUT;
            end
          end
        end
        S_RD: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (cmp.ge) begin
            pos       <= CNT_W'(idx);
            res_found <= cmp.eq;
            state     <= S_DECIDE;
          end else if (idx_inc == held) begin
            pos   <= held;
            state <= S_DECIDE;
          end else begin
            idx   <= idx_inc[ADDR_W-1:0];
            state <= S_RD;
          end
        end
        S_DECIDE: begin
          shift_idx <= held;
          if (req_code == REQ_QUERY || res_found) begin
            state <= S_OUT;
          end else if (held == CNT_W'(CAPACITY)) begin
            res_status <= 1'b1;
            state      <= S_OUT;
          end else if (held == pos) begin
            state <= S_PUT;
          end else begin
            state <= S_SHRD;
          end
        end
        S_SHRD: begin
          state <= S_SHWR;
        end
        S_SHWR: begin
          shift_idx <= shift_dec;
          state     <= (shift_dec == pos) ? S_PUT : S_SHRD;
        end
        S_PUT: begin
          held  <= held + CNT_W'(1);
          state <= S_OUT;
        end
        S_OUT: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid  <= 1'b1;
            rsp.found  <= res_found;
            rsp.status <= res_status;
            rsp.count  <= 7'(held);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= CNT_W'(CAPACITY))
    else $error("Held count exceeds capacity.");

  a_shift_above_pos: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHWR) |-> (shift_idx > pos))
    else $error("Shift writes at or below the insert position.");

  a_full_no_put: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUT) |-> (held < CNT_W'(CAPACITY)))
    else $error("Insert into a full set.");

  a_status_not_found: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.status && rsp.found))
    else $error("Dropped insert reported as found.");
`endif

endmodule

### tb/sset_scoreboard_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted set scoreboard
// Keeps its own ascending copy of the set, works out the result of every
// accepted request and compares each returned result against it in order.
// ----------------------------------------------------------------------------
package sset_scoreboard_pkg;

  import sset_pkg::*;

  class sset_scoreboard;

    logic signed [31:0] held [CAPACITY];
    int unsigned        held_n;
    rsp_t               expected_rsp [$];
    int unsigned        mismatches;
    int unsigned        checked;
    int unsigned        inserts;
    int unsigned        queries;
    int unsigned        clears;
    int unsigned        hits;
    int unsigned        drops;
    int unsigned        max_held;

    function new();
      held_n     = 0;
      mismatches = 0;
      checked    = 0;
      inserts    = 0;
      queries    = 0;
      clears     = 0;
      hits       = 0;
      drops      = 0;
      max_held   = 0;
    endfunction

    function void note_request(req_t item);
      logic signed [31:0] v;
      rsp_t               e;
      int unsigned        pos;
      int unsigned        j;
      v = item.value;
      e = '0;
      case (item.req_type)
        REQ_CLEAR: begin
          held_n = 0;
          clears++;
        end
        REQ_INSERT, REQ_QUERY: begin
          pos = 0;
          while (pos < held_n && held[pos] < v) pos++;
          if (pos < held_n && held[pos] == v) begin
            e.found = 1'b1;
            hits++;
          end
          if (item.req_type == REQ_INSERT) begin
            inserts++;
            if (!e.found) begin
              if (held_n >= CAPACITY) begin
                e.status = 1'b1;
                drops++;
              end else begin
                for (j = held_n; j > pos; j--) held[j] = held[j-1];
                held[pos] = v;
                held_n++;
                if (held_n > max_held) max_held = held_n;
              end
            end
          end else begin
            queries++;
          end
        end
        default: begin
        end
      endcase
      e.count = 7'(held_n);
      expected_rsp.push_back(e);
    endfunction

    function void check_response(rsp_t got);
      rsp_t e;
      checked++;
      if (expected_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Result %0d arrived with no request outstanding: found=%0b status=%0b count=%0d",
                   checked, got.found, got.status, got.count);
        return;
      end
      e = expected_rsp.pop_front();
      if (got.found !== e.found || got.status !== e.status || got.count !== e.count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Result %0d mismatch: expected found=%0b status=%0b count=%0d, got found=%0b status=%0b count=%0d",
                   checked, e.found, e.status, e.count, got.found, got.status, got.count);
      end
    endfunction

  endclass

endpackage

### tb/sorted_set_insert_lookup_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted set insert and lookup testbench
// Drives clear, insert, query and unused requests with random gaps on both
// handshakes, fills the set near and often past capacity, and checks every result
// item against a scoreboard that mirrors the ordered set.
// ----------------------------------------------------------------------------
module sorted_set_insert_lookup_test;

  import sset_pkg::*;
  import sset_scoreboard_pkg::*;

  localparam logic [1:0]  REQ_UNUSED = 2'd3;
  localparam logic [31:0] MIN_VAL    = 32'h8000_0000;
  localparam logic [31:0] MAX_VAL    = 32'h7FFF_FFFF;
  localparam int          ITEM_GOAL  = 1100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  sset_scoreboard board;
  bit             idle_on = 1'b1;
  int unsigned    stim_items = 0;

  sorted_set_insert_lookup i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic send_request(input logic [1:0] kind, input logic [31:0] val);
    req_t        item;
    int unsigned gap;
    item.req_type = kind;
    item.value    = val;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    board.note_request(item);
    @(negedge clk);
    if (kind != REQ_UNUSED) stim_items++;
  endtask

  initial begin
    int unsigned stall;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 9) : 0;
      if (stall != 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
      board.check_response(rsp);
      @(negedge clk);
    end
  end

  initial begin
    #2000000;
    $display("FAIL sorted_set_insert_lookup");
    $finish;
  end

  initial begin
    logic [31:0] pool [72];
    logic [31:0] base;
    logic [31:0] stride;
    logic [31:0] tmp;
    logic [31:0] v;
    int unsigned psize;
    int unsigned len;
    int unsigned op;
    int unsigned fills;
    int          i;
    int          j;

    board = new();
    fills = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed opening: extremes, duplicates, the unused code and clear.
    send_request(REQ_QUERY,  32'd0);
    send_request(REQ_INSERT, 32'd0);
    send_request(REQ_INSERT, MIN_VAL);
    send_request(REQ_INSERT, MAX_VAL);
    send_request(REQ_INSERT, 32'hFFFF_FFFF);
    send_request(REQ_INSERT, 32'd1);
    send_request(REQ_INSERT, 32'd0);
    send_request(REQ_QUERY,  MIN_VAL);
    send_request(REQ_QUERY,  MAX_VAL);
    send_request(REQ_QUERY,  32'd2);
    send_request(REQ_UNUSED, 32'hFFFF_FFFF);
    send_request(REQ_INSERT, 32'hFFFF_FFFE);
    send_request(REQ_QUERY,  32'hFFFF_FFFF);
    send_request(REQ_INSERT, MAX_VAL);
    send_request(REQ_CLEAR,  32'h5A5A_5A5A);
    send_request(REQ_QUERY,  32'hFFFF_FFFF);
    send_request(REQ_UNUSED, 32'd0);
    send_request(REQ_INSERT, 32'h5555_5555);
    send_request(REQ_INSERT, 32'hAAAA_AAAA);
    send_request(REQ_QUERY,  32'h5555_5555);
    send_request(REQ_QUERY,  32'hAAAA_AAAB);
    send_request(REQ_CLEAR,  32'hFFFF_FFFF);

    while (stim_items < ITEM_GOAL) begin
      idle_on = ($urandom_range(0, 3) != 0);
      op = $urandom_range(0, 9);
      if (op <= 3) begin
        // Fill a cleared set from a shuffled pool, often past capacity.
        fills++;
        send_request(REQ_CLEAR, $urandom());
        psize  = $urandom_range(60, 72);
        base   = $urandom();
        stride = $urandom_range(1, 1 << 20);
        for (i = 0; i < psize; i++) pool[i] = base + i * stride;
        for (i = psize - 1; i > 0; i--) begin
          j       = $urandom_range(0, i);
          tmp     = pool[i];
          pool[i] = pool[j];
          pool[j] = tmp;
        end
        for (i = 0; i < psize; i++) begin
          send_request(REQ_INSERT, pool[i]);
          if ($urandom_range(0, 3) == 0)
            send_request(REQ_QUERY, pool[$urandom_range(0, psize - 1)]);
          if ($urandom_range(0, 9) == 0)
            send_request(REQ_INSERT, pool[$urandom_range(0, i)]);
        end
        repeat ($urandom_range(4, 12)) begin
          case ($urandom_range(0, 2))
            0:       send_request(REQ_INSERT, pool[$urandom_range(0, psize - 1)]);
            1:       send_request(REQ_INSERT, $urandom());
            default: send_request(REQ_QUERY, pool[$urandom_range(0, psize - 1)]);
          endcase
        end
      end else if (op <= 6) begin
        // Crowded values around zero and both extremes.
        len = $urandom_range(20, 60);
        repeat (len) begin
          case ($urandom_range(0, 2))
            0:       v = 32'($urandom_range(0, 12)) - 32'd6;
            1:       v = MIN_VAL + $urandom_range(0, 5);
            default: v = MAX_VAL - $urandom_range(0, 5);
          endcase
          j = $urandom_range(0, 19);
          if (j < 9)       send_request(REQ_INSERT, v);
          else if (j < 17) send_request(REQ_QUERY, v);
          else if (j == 17) send_request(REQ_CLEAR, v);
          else             send_request(2'($urandom_range(0, 3)), v);
        end
      end else if (op <= 8) begin
        len = $urandom_range(20, 40);
        repeat (len) begin
          j = $urandom_range(0, 9);
          if (j < 5)       send_request(REQ_INSERT, $urandom());
          else if (j < 9)  send_request(REQ_QUERY, $urandom());
          else             send_request(REQ_UNUSED, $urandom());
        end
      end else begin
        len = $urandom_range(5, 15);
        repeat (len) send_request(2'($urandom_range(0, 3)), $urandom());
      end
    end

    req_valid <= 1'b0;
    while (board.expected_rsp.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("Checked %0d results: %0d inserts, %0d queries, %0d clears, %0d fill passes.",
             board.checked, board.inserts, board.queries, board.clears, fills);
    $display("Values found already held: %0d, inserts dropped on a full set: %0d, peak size %0d.",
             board.hits, board.drops, board.max_held);
    if (board.mismatches == 0 && board.expected_rsp.size() == 0) begin
      $display("PASS sorted_set_insert_lookup");
    end else begin
      $display("FAIL sorted_set_insert_lookup");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/sset_pkg.sv
hw/rtl/sset_mem.sv
hw/rtl/sset_cmp.sv
hw/rtl/sorted_set_insert_lookup.sv
tb/sset_scoreboard_pkg.sv
tb/sorted_set_insert_lookup_test.sv
